@@ rtl/alc_pkg.sv @@
// Package for the ANSI-aware line clipper: parser modes, command word type,
// escape constants and the reset-sequence table. Depends on nothing.
`default_nettype none

package alc_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned WidthW        = 16;
  localparam int unsigned MaxWidthRst   = 80;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned CutLen        = 4;
  localparam int unsigned SeqW          = $clog2(CutLen);

  localparam logic [ByteW-1:0] EscByte  = 8'h1B;
  localparam logic [ByteW-1:0] CsiOpen  = 8'h5B;
  localparam logic [ByteW-1:0] FinalLo  = 8'h40;
  localparam logic [ByteW-1:0] FinalHi  = 8'h7E;
  localparam logic [ByteW-1:0] ContMask = 8'hC0;
  localparam logic [ByteW-1:0] ContTag  = 8'h80;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_e;

  typedef enum logic {
    CMD_PASS = 1'b0,
    CMD_CUT  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  function automatic logic [ByteW-1:0] reset_seq_byte(input logic [SeqW-1:0] idx);
    logic [ByteW-1:0] b;
    unique case (idx)
      2'd0:    b = EscByte;
      2'd1:    b = CsiOpen;
      2'd2:    b = 8'h30;
      default: b = 8'h6D;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/alc_stream_if.sv @@
// Valid/ready stream interfaces for the line clipper: input text words and
// output clipped words. Depends on alc_pkg for the byte width.
`default_nettype none

interface alc_in_if;
  logic                     valid;
  logic                     ready;
  logic [alc_pkg::ByteW-1:0] text_byte;
  logic                     line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface alc_out_if;
  logic                     valid;
  logic                     ready;
  logic [alc_pkg::ByteW-1:0] out_byte;
  logic                     out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/ansi_aware_line_clipper.sv @@
// ANSI-aware line clipper: an accepted input word goes through a queue entry
// and then the output register; one word per cycle each way while the queue is
// not full and the output is ready; a cut line's reset sequence is four words.
// Reset (asynchronous, active low) clears parser state, queue and output
// register; max_width returns to 80. Depends on alc_pkg and alc_stream_if.
`default_nettype none

module ansi_aware_line_clipper #(
  parameter int unsigned QueueDepth = alc_pkg::QueueDepthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  alc_in_if.sink                          text_i,
  alc_out_if.source                       clip_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [alc_pkg::WidthW-1:0] cfg_wdata_i
);

  alc_pkg::push_t push;
  alc_pkg::head_t head;
  logic           q_full;
  logic           pop;

  alc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  alc_queue #(
    .QDepth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  alc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .clip_o (clip_o)
  );

endmodule

`default_nettype wire

@@ rtl/alc_front.sv @@
// Front end: accepts input words, tracks escape/CSI state and visible columns,
// and issues pass or cut commands. Depends on alc_pkg and alc_in_if.
`default_nettype none

module alc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  alc_in_if.sink                          text_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [alc_pkg::WidthW-1:0] cfg_wdata_i,
  input  wire logic                       q_full_i,
  output alc_pkg::push_t                  push_o
);

  alc_pkg::mode_e              mode_q, mode_d;
  logic [alc_pkg::WidthW-1:0]  col_q, col_d;
  logic                        cut_q, cut_d;
  logic [alc_pkg::WidthW-1:0]  max_width_q;
  logic                        accept;
  logic [alc_pkg::ByteW-1:0]   b;
  logic                        is_cont;
  logic                        is_final;
  logic                        at_limit;

  assign text_i.ready = !q_full_i;
  assign accept       = text_i.valid && !q_full_i;
  assign b            = text_i.text_byte;
  assign is_cont      = (b & alc_pkg::ContMask) == alc_pkg::ContTag;
  assign is_final     = (b >= alc_pkg::FinalLo) && (b <= alc_pkg::FinalHi);
  assign at_limit     = col_q >= max_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q <= alc_pkg::WidthW'(alc_pkg::MaxWidthRst);
    end else if (cfg_we_i) begin
      max_width_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    mode_d = mode_q;
    col_d  = col_q;
    cut_d  = cut_q;
    if (!cut_q) begin
      unique case (mode_q)
        alc_pkg::MODE_ESC: begin
          mode_d = (b == alc_pkg::CsiOpen) ? alc_pkg::MODE_CSI : alc_pkg::MODE_TEXT;
        end
        alc_pkg::MODE_CSI: begin
          if (is_final) mode_d = alc_pkg::MODE_TEXT;
        end
        default: begin
          if (b == alc_pkg::EscByte) begin
            mode_d = alc_pkg::MODE_ESC;
          end else if (!is_cont) begin
            if (at_limit) cut_d = 1'b1;
            else          col_d = col_q + 1'b1;
          end
        end
      endcase
    end
    if (text_i.line_end) begin
      mode_d = alc_pkg::MODE_TEXT;
      col_d  = '0;
      cut_d  = 1'b0;
    end
  end

  always_comb begin
    push_o.push     = accept && !cut_q;
    push_o.cmd.kind = alc_pkg::CMD_PASS;
    push_o.cmd.data = b;
    push_o.cmd.last = text_i.line_end;
    unique case (mode_q) inside
      alc_pkg::MODE_ESC, alc_pkg::MODE_CSI: begin
        push_o.cmd.kind = alc_pkg::CMD_PASS;
      end
      default: begin
        if (b != alc_pkg::EscByte && !is_cont && at_limit) begin
          push_o.cmd.kind = alc_pkg::CMD_CUT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= alc_pkg::MODE_TEXT;
      col_q  <= '0;
      cut_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      col_q  <= col_d;
      cut_q  <= cut_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/alc_queue.sv @@
// Command queue between front and back ends: small circular buffer of
// command words. Depends on alc_pkg.
`default_nettype none

module alc_queue #(
  parameter int unsigned QDepth = alc_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire alc_pkg::push_t push_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output alc_pkg::head_t     head_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  alc_pkg::cmd_t   mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = count_q == CntW'(QDepth);
  assign head_o.valid = count_q != '0;
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/alc_back.sv @@
// Back end: carries out queued commands, passing a word or expanding a cut
// into the four-word attribute reset, through an output register.
// Depends on alc_pkg and alc_out_if.
`default_nettype none

module alc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire alc_pkg::head_t head_i,
  output logic                pop_o,
  alc_out_if.source           clip_o
);

  logic [alc_pkg::SeqW-1:0]  seq_q, seq_d;
  logic                      valid_q, valid_d;
  logic [alc_pkg::ByteW-1:0] data_q, data_d;
  logic                      last_q, last_d;
  logic                      load;
  logic                      seq_end;

  assign load    = !valid_q || clip_o.ready;
  assign seq_end = seq_q == alc_pkg::SeqW'(alc_pkg::CutLen - 1);

  always_comb begin
    seq_d   = seq_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_i.valid;
      if (head_i.valid) begin
        case (head_i.cmd.kind)
          alc_pkg::CMD_CUT: begin
            data_d = alc_pkg::reset_seq_byte(seq_q);
            last_d = seq_end;
            pop_o  = seq_end;
            seq_d  = seq_end ? '0 : seq_q + 1'b1;
          end
          default: begin
            data_d = head_i.cmd.data;
            last_d = head_i.cmd.last;
            pop_o  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign clip_o.valid    = valid_q;
  assign clip_o.out_byte = data_q;
  assign clip_o.out_last = last_q;

endmodule

`default_nettype wire
